// ----- rtl/bpa_pkg.sv -----
// Shared types and constants of the bitmap page allocator.
`default_nettype none

package bpa_pkg;

	localparam int PAGE_W  = 12;
	localparam int COUNT_W = 13;
	localparam int LIMIT_W = 13;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

	// Register index as decoded from paddr[2].
	localparam logic REG_PAGE_LIMIT = 1'b0;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NO_SPACE = 1'b1;

	typedef enum logic [8:0] {
		ST_INIT   = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_DIV    = 9'b000000100,
		ST_REM    = 9'b000001000,
		ST_CHECK  = 9'b000010000,
		ST_SCAN   = 9'b000100000,
		ST_PREAD  = 9'b001000000,
		ST_PWRITE = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/bitmap_page_allocator.sv -----
// Next-fit bitmap page allocator with a word-wide bitmap memory and a scan sequencer.
//
// Usage: each request on the s_ channel either allocates a run of count contiguous
// free pages (s_tuser = 0) or frees count pages from page_index on (s_tuser = 1).
// Every request yields one response on the m_ channel: status in m_tuser (0 ok,
// 1 no space) and the first page of the allocated run in m_tdata (0 otherwise).
// The APB port holds page_limit at address 0; write it only while the block is idle.
// The bitmap sits in one memory of WORD_BITS-bit words, one read or one write a cycle.
// An allocation scans from the next-fit pointer: a word that lies wholly inside the
// scan range and is all used or all free is judged whole in ST_CHECK and ST_SCAN, any
// other word goes through ST_SCAN page by page. Marking the run then reads, modifies
// and writes each word touched (ST_PREAD, ST_PWRITE). A free locates its first word
// in ST_DIV and ST_REM and then reads and writes each word touched. The response is
// registered from ST_DONE once the output slot is free; s_tready is high only while
// the sequencer is idle. After reset the block runs a clearing pass that writes every
// word to all ones (every page used), one word after another, and no request is taken
// meanwhile. A stalled response waits in the output register; the next request is
// accepted meanwhile and its response is held until the slot frees.
`default_nettype none

module bitmap_page_allocator #(
	parameter int NUM_PAGES = 4096,
	parameter int WORD_BITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request: [11:0] page_index, [24:12] count, rest zero.
	input  wire logic [31:0] s_tdata,
	// Request: [0] mode.
	input  wire logic        s_tuser,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// Response: [11:0] first_page, rest zero.
	output logic [15:0]      m_tdata,
	// Response: [0] status.
	output logic             m_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	import bpa_pkg::*;

	localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int WW = $clog2(MAP_WORDS + 1);
	localparam int BW = $clog2(WORD_BITS);
	localparam int NW = $clog2(WORD_BITS + 1);
	localparam logic [LIMIT_W-1:0] LIM_CAP = 13'((NUM_PAGES > 8191) ? 8191 : NUM_PAGES);
	localparam logic [LIMIT_W-1:0] WB13 = 13'(WORD_BITS);
	// page / WORD_BITS is taken as (page * RECIP) >> 20, exact for pages below 4096.
	localparam int RECIP_SH = 20;
	localparam logic [17:0] RECIP = 18'(((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS);

	logic [WORD_BITS-1:0] mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	state_t               state_q;
	logic [LIMIT_W-1:0]   page_limit_q;
	logic [AW-1:0]        init_q;
	logic [LIMIT_W-1:0]   pg_q;
	logic [WW-1:0]        w_q;
	logic [BW-1:0]        b_q;
	logic [LIMIT_W-1:0]   end_q;
	logic                 pass_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [COUNT_W-1:0]   run_q;
	logic [LIMIT_W-1:0]   rs_pg_q;
	logic [WW-1:0]        rs_w_q;
	logic [BW-1:0]        rs_b_q;
	logic [LIMIT_W-1:0]   st_pg_q;
	logic [LIMIT_W-1:0]   ptr_pg_q;
	logic [WW-1:0]        ptr_w_q;
	logic [BW-1:0]        ptr_b_q;
	logic [COUNT_W-1:0]   rem_q;
	logic                 set_q;
	logic [9:0]           quo_q;
	logic                 res_status_q;
	logic [PAGE_W-1:0]    res_first_q;

	logic [LIMIT_W-1:0]   lim;
	logic                 cfg_wr;
	logic [LIMIT_W-1:0]   in_page;
	logic [COUNT_W-1:0]   in_count;
	logic [LIMIT_W-1:0]   free_room;
	logic [COUNT_W-1:0]   free_rem;
	logic [29:0]          quo_prod;
	logic [LIMIT_W-1:0]   bit_off;
	logic                 all_used;
	logic                 all_free;
	logic                 fast;
	logic                 bit_free;
	logic                 b_last;
	logic [COUNT_W-1:0]   run_inc;
	logic [COUNT_W:0]     run_plus_w;
	logic [LIMIT_W-1:0]   start_pg;
	logic [WW-1:0]        start_w;
	logic [BW-1:0]        start_b;
	logic [NW-1:0]        room;
	logic [NW-1:0]        n_bits;
	logic [NW-1:0]        bn;
	logic [WORD_BITS-1:0] mask;
	logic                 mem_we;
	logic                 mem_re;
	logic [AW-1:0]        mem_addr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 out_free;

	assign lim      = (page_limit_q < LIM_CAP) ? page_limit_q : LIM_CAP;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_PAGE_LIMIT) ? {19'd0, page_limit_q} : 32'd0;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid || m_tready;

	assign in_page  = {1'b0, s_tdata[11:0]};
	assign in_count = s_tdata[24:12];
	assign free_room = lim - in_page;
	always_comb begin
		if (in_page >= lim) begin
			free_rem = '0;
		end else if (in_count < free_room) begin
			free_rem = in_count;
		end else begin
			free_rem = free_room;
		end
	end

	assign quo_prod = 30'(pg_q[11:0]) * 30'(RECIP);
	assign bit_off  = pg_q - (13'(quo_q) * WB13);

	// Scan datapath over the word held in rdata_q.
	assign all_used   = &rdata_q;
	assign all_free   = ~|rdata_q;
	assign fast       = (b_q == '0) && ((end_q - pg_q) >= WB13);
	assign bit_free   = !rdata_q[b_q];
	assign b_last     = (b_q == BW'(WORD_BITS - 1));
	assign run_inc    = run_q + 13'd1;
	assign run_plus_w = {1'b0, run_q} + 14'(WORD_BITS);
	assign start_pg   = (run_q == '0) ? pg_q : rs_pg_q;
	assign start_w    = (run_q == '0) ? w_q  : rs_w_q;
	assign start_b    = (run_q == '0) ? b_q  : rs_b_q;

	// Bits [b_q, b_q + n_bits) of the current word are marked or cleared.
	assign room   = NW'(WORD_BITS) - NW'(b_q);
	assign n_bits = (rem_q < 13'(room)) ? NW'(rem_q) : room;
	assign bn     = NW'(b_q) + n_bits;
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			mask[j] = (NW'(j) >= NW'(b_q)) && (NW'(j) < bn);
		end
	end

	assign mem_we    = (state_q == ST_INIT) || (state_q == ST_PWRITE);
	assign mem_re    = (state_q == ST_CHECK) || (state_q == ST_PREAD);
	assign mem_addr  = (state_q == ST_INIT) ? init_q : w_q[AW-1:0];
	assign mem_wdata = (state_q == ST_INIT) ? {WORD_BITS{1'b1}} :
		(set_q ? (rdata_q | mask) : (rdata_q & ~mask));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			page_limit_q <= LIMIT_RESET;
			init_q       <= '0;
			pg_q         <= '0;
			w_q          <= '0;
			b_q          <= '0;
			end_q        <= '0;
			pass_q       <= 1'b0;
			cnt_q        <= '0;
			run_q        <= '0;
			rs_pg_q      <= '0;
			rs_w_q       <= '0;
			rs_b_q       <= '0;
			st_pg_q      <= '0;
			ptr_pg_q     <= '0;
			ptr_w_q      <= '0;
			ptr_b_q      <= '0;
			rem_q        <= '0;
			set_q        <= 1'b0;
			quo_q        <= '0;
			res_status_q <= STATUS_OK;
			res_first_q  <= '0;
			m_tvalid     <= 1'b0;
			m_tuser      <= 1'b0;
			m_tdata      <= '0;
		end else begin
			if (cfg_wr && (paddr[2] == REG_PAGE_LIMIT)) begin
				page_limit_q <= pwdata[LIMIT_W-1:0];
			end
			// In ST_DONE the slot is refilled below whenever it drains.
			if (m_tvalid && m_tready && (state_q != ST_DONE)) begin
				m_tvalid <= 1'b0;
			end

			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + AW'(1);
					if (init_q == AW'(MAP_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end

				ST_IDLE: begin
					if (s_tvalid) begin
						cnt_q        <= in_count;
						run_q        <= '0;
						res_first_q  <= '0;
						if (s_tuser == MODE_FREE) begin
							res_status_q <= STATUS_OK;
							pg_q  <= in_page;
							rem_q <= free_rem;
							set_q <= 1'b0;
							state_q <= (free_rem == '0) ? ST_DONE : ST_DIV;
						end else if ((in_count == '0) || (lim == '0)) begin
							res_status_q <= STATUS_NO_SPACE;
							state_q      <= ST_DONE;
						end else begin
							res_status_q <= STATUS_OK;
							end_q   <= lim;
							state_q <= ST_CHECK;
							if (ptr_pg_q < lim) begin
								pg_q   <= ptr_pg_q;
								w_q    <= ptr_w_q;
								b_q    <= ptr_b_q;
								pass_q <= 1'b0;
							end else begin
								// Pointer at or past the limit: go straight to the wrap pass.
								pg_q   <= '0;
								w_q    <= '0;
								b_q    <= '0;
								pass_q <= 1'b1;
							end
						end
					end
				end

				ST_DIV: begin
					quo_q   <= quo_prod[29:20];
					state_q <= ST_REM;
				end

				ST_REM: begin
					w_q     <= WW'(quo_q);
					b_q     <= BW'(bit_off);
					state_q <= ST_PREAD;
				end

				ST_CHECK: begin
					if (pg_q == end_q) begin
						if (!pass_q) begin
							// Wrap pass covers pages below the old pointer.
							pg_q   <= '0;
							w_q    <= '0;
							b_q    <= '0;
							end_q  <= ptr_pg_q;
							pass_q <= 1'b1;
							run_q  <= '0;
						end else begin
							res_status_q <= STATUS_NO_SPACE;
							state_q      <= ST_DONE;
						end
					end else begin
						state_q <= ST_SCAN;
					end
				end

				ST_SCAN: begin
					if (fast && all_used) begin
						run_q   <= '0;
						pg_q    <= pg_q + WB13;
						w_q     <= w_q + WW'(1);
						state_q <= ST_CHECK;
					end else if (fast && all_free) begin
						if (run_plus_w >= {1'b0, cnt_q}) begin
							st_pg_q <= start_pg;
							pg_q    <= start_pg;
							w_q     <= start_w;
							b_q     <= start_b;
							rem_q   <= cnt_q;
							set_q   <= 1'b1;
							state_q <= ST_PREAD;
						end else begin
							if (run_q == '0) begin
								rs_pg_q <= pg_q;
								rs_w_q  <= w_q;
								rs_b_q  <= b_q;
							end
							run_q   <= run_plus_w[COUNT_W-1:0];
							pg_q    <= pg_q + WB13;
							w_q     <= w_q + WW'(1);
							state_q <= ST_CHECK;
						end
					end else if (bit_free && (run_inc == cnt_q)) begin
						st_pg_q <= start_pg;
						pg_q    <= start_pg;
						w_q     <= start_w;
						b_q     <= start_b;
						rem_q   <= cnt_q;
						set_q   <= 1'b1;
						state_q <= ST_PREAD;
					end else begin
						if (bit_free) begin
							if (run_q == '0) begin
								rs_pg_q <= pg_q;
								rs_w_q  <= w_q;
								rs_b_q  <= b_q;
							end
							run_q <= run_inc;
						end else begin
							run_q <= '0;
						end
						pg_q <= pg_q + 13'd1;
						if (b_last) begin
							w_q     <= w_q + WW'(1);
							b_q     <= '0;
							state_q <= ST_CHECK;
						end else begin
							b_q <= b_q + BW'(1);
							if ((pg_q + 13'd1) == end_q) begin
								state_q <= ST_CHECK;
							end
						end
					end
				end

				ST_PREAD: begin
					state_q <= ST_PWRITE;
				end

				ST_PWRITE: begin
					pg_q  <= pg_q + 13'(n_bits);
					rem_q <= rem_q - 13'(n_bits);
					if (bn == NW'(WORD_BITS)) begin
						w_q <= w_q + WW'(1);
						b_q <= '0;
					end else begin
						b_q <= BW'(bn);
					end
					if (rem_q == 13'(n_bits)) begin
						if (set_q) begin
							// The pointer lands just past the new run.
							ptr_pg_q    <= pg_q + 13'(n_bits);
							ptr_w_q     <= (bn == NW'(WORD_BITS)) ? (w_q + WW'(1)) : w_q;
							ptr_b_q     <= (bn == NW'(WORD_BITS)) ? '0 : BW'(bn);
							res_first_q <= st_pg_q[PAGE_W-1:0];
						end
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_PREAD;
					end
				end

				ST_DONE: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tuser  <= res_status_q;
						m_tdata  <= {4'd0, res_first_q};
						state_q  <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (pg_q < end_q))
		else $error("scan position outside the search range");

	a_run_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (run_q < cnt_q))
		else $error("free run reached the count without completing the allocation");

	a_patch_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PWRITE) |-> ((rem_q != '0) && (n_bits != '0)))
		else $error("bitmap update with nothing left to write");

	a_resp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("response issued outside the completion state");

	a_ok_run_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PWRITE && set_q) |-> ((pg_q + 13'(n_bits)) <= lim))
		else $error("allocated run extends past the page limit");

endmodule

`default_nettype wire

// ----- tb/sv/bitmap_page_allocator_checker.sv -----
// Checker for the bitmap page allocator: tracks the page bitmap and compares every response.
`timescale 1ns / 1ps

module bitmap_page_allocator_checker #(
	parameter int NUM_PAGES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [31:0] s_tdata,
	input  wire logic        s_tuser,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [15:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic [31:0] prdata,
	input  wire logic        pready,
	output int               errors,
	output int               outstanding,
	output int               granted,
	output int               refused,
	output int               freed
);

	import bpa_pkg::*;

	typedef struct packed {
		logic              status;
		logic [PAGE_W-1:0] first_page;
	} page_grant_t;

	bit [NUM_PAGES-1:0] used_map;
	int                 search_ptr;
	logic [LIMIT_W-1:0] limit_reg;
	page_grant_t        grant_q[$];

	// Looks for cnt free pages in a row within [from, to).
	function automatic bit find_free_run(int from, int to, int cnt, output int start);
		int run;
		int p;
		run = 0;
		start = 0;
		for (p = from; p < to; p++) begin
			if (!used_map[p]) begin
				run++;
				if (run == cnt) begin
					start = p + 1 - cnt;
					return 1'b1;
				end
			end else begin
				run = 0;
			end
		end
		return 1'b0;
	endfunction

	function automatic page_grant_t serve_request(logic mode, logic [PAGE_W-1:0] page,
			logic [COUNT_W-1:0] cnt);
		page_grant_t res;
		int lim;
		int old;
		int start;
		int i;
		bit found;
		lim = (int'(limit_reg) < NUM_PAGES) ? int'(limit_reg) : NUM_PAGES;
		res.status = STATUS_OK;
		res.first_page = '0;
		found = 1'b0;
		start = 0;
		if (mode == MODE_FREE) begin
			for (i = 0; i < int'(cnt); i++) begin
				if (int'(page) + i >= lim)
					break;
				used_map[int'(page) + i] = 1'b0;
			end
			return res;
		end
		if (cnt != 0 && lim != 0) begin
			old = search_ptr;
			if (old < lim)
				found = find_free_run(old, lim, int'(cnt), start);
			// The wrap pass never crosses the old pointer, so runs do not span the wrap.
			if (!found)
				found = find_free_run(0, (old < lim) ? old : lim, int'(cnt), start);
		end
		if (found) begin
			for (i = 0; i < int'(cnt); i++)
				used_map[start + i] = 1'b1;
			search_ptr = start + int'(cnt);
			res.first_page = start[PAGE_W-1:0];
		end else begin
			res.status = STATUS_NO_SPACE;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		page_grant_t due;
		page_grant_t got;
		if (!arst_n) begin
			used_map = '1;
			search_ptr = 0;
			limit_reg = LIMIT_RESET;
			grant_q.delete();
			errors = 0;
			outstanding = 0;
			granted = 0;
			refused = 0;
			freed = 0;
		end else begin
			if (psel && penable && pready && paddr[2] == REG_PAGE_LIMIT) begin
				if (pwrite) begin
					limit_reg = pwdata[LIMIT_W-1:0];
				end else if (prdata !== 32'(limit_reg)) begin
					$error("page_limit: expected %0d, got %0d", limit_reg, prdata);
					errors++;
				end
			end
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.first_page = m_tdata[PAGE_W-1:0];
				if (grant_q.size() == 0) begin
					$error("response with no request waiting: status %0d, first_page %0d",
						got.status, got.first_page);
					errors++;
				end else begin
					due = grant_q.pop_front();
					if (got.status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, got.status);
						errors++;
					end
					if (got.first_page !== due.first_page) begin
						$error("first_page: expected %0d, got %0d", due.first_page,
							got.first_page);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				due = serve_request(s_tuser, s_tdata[PAGE_W-1:0],
					s_tdata[PAGE_W +: COUNT_W]);
				grant_q.push_back(due);
				if (s_tuser == MODE_FREE)
					freed++;
				else if (due.status == STATUS_OK)
					granted++;
				else
					refused++;
			end
			outstanding = grant_q.size();
		end
	end

endmodule

// ----- tb/sv/bitmap_page_allocator_tb.sv -----
// Testbench top for the bitmap page allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module bitmap_page_allocator_tb;
	import bpa_pkg::*;

	localparam int             PHASE_REQUESTS = 55;
	localparam int             SQUEEZE_CYCLES = 400;
	localparam logic [2:0]     PAGE_LIMIT_ADDR = {REG_PAGE_LIMIT, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = MODE_ALLOC;
	logic        s_tvalid = 1'b0;
	wire logic   s_tready;
	wire logic [15:0] m_tdata;
	wire logic   m_tuser;
	wire logic   m_tvalid;
	logic        m_tready = 1'b1;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire logic [31:0] prdata;
	wire logic   pready;

	int errors;
	int outstanding;
	int granted;
	int refused;
	int freed;
	int sent = 0;
	int settings = 0;
	bit tx_gaps = 1'b1;
	bit rx_stalls = 1'b1;
	bit squeeze_req = 1'b0;

	always #2 clk = ~clk;

	bitmap_page_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bitmap_page_allocator_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.errors(errors), .outstanding(outstanding),
		.granted(granted), .refused(refused), .freed(freed)
	);

	task automatic send_request(logic mode, logic [PAGE_W-1:0] page,
			logic [COUNT_W-1:0] cnt);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= 32'({cnt, page});
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic request_gap();
		int g;
		int pick;
		pick = $urandom_range(99);
		if (!tx_gaps || pick < 55)
			return;
		g = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		s_tvalid <= 1'b0;
		repeat (g) @(posedge clk);
	endtask

	task automatic random_request(int lim);
		logic mode;
		int eff;
		int page;
		int cnt;
		int pick;
		eff = (lim > 4096) ? 4096 : lim;
		mode = ($urandom_range(99) < 45) ? MODE_FREE : MODE_ALLOC;
		// Most pages fall inside the managed range; a few are drawn from the whole page range and may lie above it.
		if (eff == 0 || $urandom_range(9) == 0)
			page = $urandom_range(4095);
		else
			page = $urandom_range(eff - 1);
		pick = $urandom_range(99);
		if (pick < 60)
			cnt = $urandom_range(1, 16);
		else if (pick < 85)
			cnt = $urandom_range(17, 128);
		else if (pick < 95)
			cnt = $urandom_range(129, 1024);
		else if (pick < 98)
			cnt = 0;
		else
			cnt = 4096;
		send_request(mode, PAGE_W'(page), COUNT_W'(cnt));
		request_gap();
	endtask

	// Drops the request side and waits until every response has been taken.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic reg_access(logic wr, logic [31:0] wdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= PAGE_LIMIT_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : sink
		int hold;
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				// Long hold so the output slot fills and the request side backs up.
				squeeze_req = 1'b0;
				m_tready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (rx_stalls && $urandom_range(9) < 3) begin
				hold = ($urandom_range(9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int limits[10];
		int ph;
		int k;
		limits = '{1, 0, 8191, 64, 300, 4096, 4095, 1000, 2048, 0};
		limits[9] = $urandom_range(1, 4096);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_access(1'b0, '0);

		// Every page starts used, so the first allocations must fail.
		send_request(MODE_ALLOC, 0, 1);
		send_request(MODE_ALLOC, 0, 0);
		request_gap();
		send_request(MODE_FREE, 0, 4096);
		send_request(MODE_ALLOC, 4095, 4096);
		send_request(MODE_ALLOC, 0, 1);
		request_gap();
		send_request(MODE_FREE, 4095, 4096);
		send_request(MODE_FREE, 100, 50);
		send_request(MODE_ALLOC, 0, 4096);
		send_request(MODE_ALLOC, 0, 50);
		send_request(MODE_ALLOC, 0, 1);
		request_gap();
		send_request(MODE_FREE, 0, 0);
		send_request(MODE_FREE, 4095, 1);
		send_request(MODE_FREE, 4095, 1);
		send_request(MODE_FREE, 0, 4096);
		send_request(MODE_ALLOC, 0, 0);
		send_request(MODE_ALLOC, 0, 10);
		send_request(MODE_ALLOC, 0, 4086);
		send_request(MODE_FREE, 2048, 4096);
		send_request(MODE_ALLOC, 1234, 2048);
		send_request(MODE_FREE, 2730, 1365);

		for (ph = 0; ph < 10; ph++) begin
			wait_drained();
			reg_access(1'b1, 32'(limits[ph]));
			reg_access(1'b0, '0);
			settings++;
			tx_gaps = (ph % 3 != 1);
			rx_stalls = (ph % 4 != 2);
			if (ph == 5) begin
				tx_gaps = 1'b0;
				squeeze_req = 1'b1;
			end
			for (k = 0; k < PHASE_REQUESTS; k++)
				random_request(limits[ph]);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d requests under %0d page-limit settings (zero, one page, above the map).",
			sent, settings);
		$display("Allocations granted %0d, refused %0d; frees %0d; one long response hold.",
			granted, refused, freed);
		if (errors == 0)
			$display("bitmap_page_allocator: match");
		else
			$display("bitmap_page_allocator: mismatch");
		$finish;
	end

	initial begin : watchdog
		#(64'd60_000_000);
		$display("bitmap_page_allocator: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/bpa_pkg.sv
rtl/bitmap_page_allocator.sv
tb/sv/bitmap_page_allocator_checker.sv
tb/sv/bitmap_page_allocator_tb.sv
